@@ rtl/assert_macros.svh @@
// Assertion helper macros for the LRU block pool checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge, held off during reset.
`define CHK_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

@@ rtl/lbp_pkg.sv @@
// ---------------------------------------------------------------------------
// lbp_pkg: shared types and constants for the LRU block pool
// Sizes, operation and status codes, sequencer states.
// ---------------------------------------------------------------------------
`default_nettype none
package lbp_pkg;
   localparam int POOL_SIZE  = 64;
   localparam int FRAME_BITS = 16;
   localparam int SLOT_W     = $clog2(POOL_SIZE);
   localparam int LINK_W     = SLOT_W + 1;
   localparam int CNT_W      = 7;
   localparam logic [CNT_W-1:0] CACHE_LIMIT_RESET = 7'd12;
   localparam logic [LINK_W-1:0] NUL = LINK_W'(POOL_SIZE);

   localparam logic [2:0] OP_GET   = 3'd0;
   localparam logic [2:0] OP_FIRST = 3'd1;
   localparam logic [2:0] OP_NEXT  = 3'd2;
   localparam logic [2:0] OP_DEL   = 3'd3;
   localparam logic [2:0] OP_FREE  = 3'd4;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_EXH   = 3'd1;
   localparam logic [2:0] ST_EMPTY = 3'd2;
   localparam logic [2:0] ST_SAME  = 3'd3;
   localparam logic [2:0] ST_LONE  = 3'd4;

   // memory word: prev, next, stamp
   localparam int WORD_W = 2*LINK_W + FRAME_BITS;

   typedef enum logic [4:0] {
      S_IDLE, S_CLR, S_DISP,
      S_G_SCAN, S_G_TAIL, S_G_TAILRD, S_G_UNL,
      S_M_RDB, S_M_RDA, S_M_DEC, S_M_FIXP, S_M_FIXN, S_M_FIXH, S_M_WRB,
      S_N_FIXANX,
      S_F_RD, S_F_CHK, S_F_END,
      S_DONE
   } state_type;
endpackage
`default_nettype wire

@@ rtl/lbp_ram.sv @@
// ---------------------------------------------------------------------------
// lbp_ram: generic single-port RAM
// One address per cycle: write on we, read always; registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module lbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem_ff[addr] <= wdata;
      rdata <= mem_ff[addr];
   end
endmodule
`default_nettype wire

@@ rtl/lru_block_pool_with_frame_stamps_unit.sv @@
// ---------------------------------------------------------------------------
// lru_block_pool_with_frame_stamps_unit: LRU recency list of block slots
// Slot pool with doubly linked recency list and per-slot frame stamps.
// ---------------------------------------------------------------------------
//   channel | ports                     | transfer
//   request | req_* fields, start       | start high while busy low
//   result  | rsp_* fields, rsp_valid   | one cycle strobe, no stall
//   config  | csr_we, csr_cache_limit   | any edge with csr_we high, reset low
// Get scans one slot per cycle for the lowest free slot while under the limit;
// at the limit or on a miss it recycles the tail if its stamp is zero or not
// the request frame, else scans once more. Delete tail / free unused free one
// tail slot per S_F_RD/S_F_CHK pass. All bound by the single-port
// link/stamp RAM. Reset: a clearing pass writes null links and stamp 0 to
// every slot; busy stays high meanwhile. The result side cannot stall.
`default_nettype none
module lru_block_pool_with_frame_stamps_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [2:0]                      req_operation,
   input  wire logic [lbp_pkg::SLOT_W-1:0]      req_block_index,
   input  wire logic [lbp_pkg::SLOT_W-1:0]      req_after_index,
   input  wire logic [lbp_pkg::CNT_W-1:0]       req_delete_count,
   input  wire logic [lbp_pkg::FRAME_BITS-1:0]  req_frame_id,
   input  wire logic                            csr_we,
   input  wire logic [lbp_pkg::CNT_W-1:0]       csr_cache_limit,
   output logic                                 rsp_valid,
   output logic [2:0]                           rsp_status,
   output logic [lbp_pkg::SLOT_W-1:0]           rsp_result_block,
   output logic [lbp_pkg::CNT_W-1:0]            rsp_freed_count,
   output logic [lbp_pkg::CNT_W-1:0]            rsp_allocated_count
);
   import lbp_pkg::*;

   // memory word unpacking
   logic                 we;
   logic [SLOT_W-1:0]    addr;
   logic [WORD_W-1:0]    wdata, rdata;
   logic [LINK_W-1:0]    rd_prev, rd_next;
   logic [FRAME_BITS-1:0] rd_stamp;
   assign rd_prev  = rdata[WORD_W-1 -: LINK_W];
   assign rd_next  = rdata[FRAME_BITS +: LINK_W];
   assign rd_stamp = rdata[FRAME_BITS-1:0];

   lbp_ram #(.WIDTH(WORD_W), .DEPTH(POOL_SIZE)) u_ram (
      .clock(clock), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
   );

   state_type state_ff, state_in;
   logic [POOL_SIZE-1:0] use_ff, use_in;
   logic [LINK_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0]  used_ff, used_in, limit_ff;
   logic [SLOT_W-1:0] ptr_ff, ptr_in;
   logic [2:0] op_ff, op_in;
   logic [SLOT_W-1:0] blk_ff, blk_in, aft_ff, aft_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in, frd_ff, frd_in;
   logic [FRAME_BITS-1:0] frm_ff, frm_in;
   // saved reads of block and after
   logic [LINK_W-1:0] bp_ff, bp_in, bn_ff, bn_in, an_ff, an_in, ap_ff, ap_in;
   logic [LINK_W-1:0] t_ff, t_in;
   logic [2:0] st_ff, st_in;
   logic [SLOT_W-1:0] res_ff, res_in;
   logic v_ff, v_in;

   function automatic logic [WORD_W-1:0] pack(logic [LINK_W-1:0] p, logic [LINK_W-1:0] n,
                                             logic [FRAME_BITS-1:0] f);
      return {p, n, f};
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR; use_ff <= '0; head_ff <= NUL; tail_ff <= NUL;
         used_ff <= '0; ptr_ff <= '0; v_ff <= 1'b0; limit_ff <= CACHE_LIMIT_RESET;
      end else begin
         state_ff <= state_in; use_ff <= use_in; head_ff <= head_in;
         tail_ff <= tail_in; used_ff <= used_in; ptr_ff <= ptr_in; v_ff <= v_in;
         if (csr_we) limit_ff <= csr_cache_limit;
      end
      op_ff <= op_in; blk_ff <= blk_in; aft_ff <= aft_in; cnt_ff <= cnt_in;
      frd_ff <= frd_in; frm_ff <= frm_in; bp_ff <= bp_in; bn_ff <= bn_in;
      an_ff <= an_in; ap_ff <= ap_in; t_ff <= t_in; st_ff <= st_in; res_ff <= res_in;
   end

   logic [LINK_W-1:0] blk_l, aft_l;
   assign blk_l = {1'b0, blk_ff};
   assign aft_l = {1'b0, aft_ff};

   always_comb begin
      state_in = state_ff; use_in = use_ff; head_in = head_ff; tail_in = tail_ff;
      used_in = used_ff; ptr_in = ptr_ff; v_in = 1'b0;
      op_in = op_ff; blk_in = blk_ff; aft_in = aft_ff; cnt_in = cnt_ff;
      frd_in = frd_ff; frm_in = frm_ff; bp_in = bp_ff; bn_in = bn_ff;
      an_in = an_ff; ap_in = ap_ff; t_in = t_ff; st_in = st_ff; res_in = res_ff;
      we = 1'b0; addr = '0; wdata = pack(NUL, NUL, '0);
      busy = (state_ff != S_IDLE);
      unique case (state_ff)
         S_CLR: begin
            we = 1'b1; addr = ptr_ff;
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == SLOT_W'(POOL_SIZE-1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               op_in = req_operation; blk_in = req_block_index;
               aft_in = req_after_index; cnt_in = req_delete_count;
               frm_in = req_frame_id; st_in = ST_OK; res_in = '0; frd_in = '0;
               ptr_in = '0;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            unique case (op_ff)
               OP_GET: state_in = (used_ff < limit_ff) ? S_G_SCAN : S_G_TAIL;
               OP_FIRST: begin
                  if (!use_ff[blk_ff]) begin
                     st_in = ST_EMPTY; state_in = S_DONE;
                  end else begin
                     addr = blk_ff; state_in = S_M_RDB;
                  end
               end
               OP_NEXT: begin
                  if (!use_ff[blk_ff] || !use_ff[aft_ff] || head_ff == NUL) begin
                     st_in = ST_EMPTY; state_in = S_DONE;
                  end else if (blk_ff == aft_ff) begin
                     st_in = ST_SAME; state_in = S_DONE;
                  end else begin
                     addr = blk_ff; state_in = S_M_RDB;
                  end
               end
               OP_DEL, OP_FREE: begin
                  if (op_ff == OP_FREE) cnt_in = used_ff;
                  state_in = S_F_RD;
               end
               default: state_in = S_DONE;
            endcase
         end
         // lowest free slot, one per cycle
         S_G_SCAN: begin
            if (!use_ff[ptr_ff]) begin
               we = 1'b1; addr = ptr_ff;
               use_in[ptr_ff] = 1'b1; used_in = used_ff + 1'b1;
               res_in = ptr_ff; state_in = S_DONE;
            end else if (ptr_ff == SLOT_W'(POOL_SIZE-1)) begin
               if (op_ff == OP_GET && used_ff < limit_ff && st_ff == ST_OK) begin
                  ptr_in = '0; state_in = S_G_TAIL;
               end else begin
                  st_in = ST_EXH; state_in = S_DONE;
               end
            end else ptr_in = ptr_ff + 1'b1;
         end
         S_G_TAIL: begin
            if (tail_ff == NUL) begin
               st_in = ST_LONE; ptr_in = '0; state_in = S_G_SCAN; // marks second try
            end else begin
               addr = tail_ff[SLOT_W-1:0]; state_in = S_G_TAILRD;
            end
         end
         S_G_TAILRD: begin
            if (rd_stamp != frm_ff || rd_stamp == '0) begin
               t_in = rd_prev;
               we = 1'b1; addr = tail_ff[SLOT_W-1:0];
               res_in = tail_ff[SLOT_W-1:0];
               if (head_ff == tail_ff) head_in = NUL;
               tail_in = rd_prev;
               state_in = (rd_prev != NUL) ? S_G_UNL : S_DONE;
            end else begin
               st_in = ST_LONE; ptr_in = '0; state_in = S_G_SCAN;
            end
         end
         S_G_UNL: begin
            // new tail's next becomes null; read-modify done with saved prev
            addr = t_ff[SLOT_W-1:0]; state_in = S_M_FIXN; bp_in = NUL; an_in = NUL;
            ap_in = t_ff; // reuse: write next of ap to an
            op_in = OP_GET;
         end
         S_M_RDB: begin
            // block entry is on the read port now
            bp_in = rd_prev; bn_in = rd_next;
            addr = aft_ff;   // read after entry (harmless for mark first)
            state_in = S_M_RDA;
         end
         S_M_RDA: begin
            addr = aft_ff;   // keep after entry on the read port for decode
            state_in = S_M_DEC;
         end
         S_M_DEC: begin
            an_in = rd_next; ap_in = rd_prev;
            if (op_ff == OP_FIRST) begin
               if (head_ff == NUL) begin
                  head_in = blk_l; tail_in = blk_l;
                  we = 1'b1; addr = blk_ff; wdata = pack(NUL, NUL, frm_ff);
                  state_in = S_DONE;
               end else if (blk_l == head_ff) begin
                  we = 1'b1; addr = blk_ff; wdata = pack(bp_ff, bn_ff, frm_ff);
                  state_in = S_DONE;
               end else begin
                  if (blk_l == tail_ff) tail_in = bp_ff;
                  t_in = head_ff;
                  state_in = S_M_FIXP;
               end
            end else begin
               if (!(aft_l == head_ff || rd_prev != NUL)) begin
                  st_in = ST_EMPTY; state_in = S_DONE;
               end else if (bp_ff == aft_l) begin
                  we = 1'b1; addr = blk_ff; wdata = pack(bp_ff, bn_ff, frm_ff);
                  state_in = S_DONE;
               end else if (blk_l == head_ff && bn_ff == NUL) begin
                  st_in = ST_LONE; state_in = S_DONE;
               end else begin
                  if (blk_l == head_ff) head_in = bn_ff;
                  if (blk_l == tail_ff) tail_in = bp_ff;
                  // if after's next is blk, detach makes it blk's next
                  if (rd_next == blk_l) an_in = bn_ff;
                  state_in = S_M_FIXP;
               end
            end
         end
         // detach: next[p] = n
         S_M_FIXP: begin
            if (bp_ff != NUL) begin
               addr = bp_ff[SLOT_W-1:0]; state_in = S_M_FIXN;
            end else state_in = S_M_FIXN;
         end
         S_M_FIXN: begin
            if (op_ff == OP_GET) begin
               we = 1'b1; addr = ap_ff[SLOT_W-1:0];
               wdata = pack(rd_prev, NUL, rd_stamp); state_in = S_DONE;
            end else begin
               if (bp_ff != NUL) begin
                  we = 1'b1; addr = bp_ff[SLOT_W-1:0];
                  wdata = pack(rd_prev, bn_ff, rd_stamp);
                  if (op_ff == OP_NEXT && bp_ff == aft_l) ap_in = rd_prev;
               end
               state_in = S_M_FIXH;
               ptr_in = '0;
            end
         end
         // prev[n] = p, then splice
         S_M_FIXH: begin
            if (ptr_ff == '0) begin
               if (bn_ff != NUL) addr = bn_ff[SLOT_W-1:0];
               ptr_in = SLOT_W'(1);
            end else if (ptr_ff == SLOT_W'(1)) begin
               if (bn_ff != NUL) begin
                  we = 1'b1; addr = bn_ff[SLOT_W-1:0];
                  wdata = pack(bp_ff, rd_next, rd_stamp);
               end
               ptr_in = SLOT_W'(2);
            end else if (ptr_ff == SLOT_W'(2)) begin
               // read the neighbor that gets blk as prev
               if (op_ff == OP_FIRST) addr = t_ff[SLOT_W-1:0];
               else addr = aft_ff;
               ptr_in = SLOT_W'(3);
            end else begin
               we = 1'b1;
               if (op_ff == OP_FIRST) begin
                  addr = t_ff[SLOT_W-1:0];
                  wdata = pack(blk_l, rd_next, rd_stamp);
                  head_in = blk_l;
                  state_in = S_M_WRB;
               end else begin
                  addr = aft_ff; an_in = rd_next;
                  wdata = pack(rd_prev, blk_l, rd_stamp);
                  if (aft_l == tail_in) tail_in = blk_l;
                  state_in = S_N_FIXANX;
                  ptr_in = '0;
               end
            end
         end
         S_N_FIXANX: begin
            if (ptr_ff == '0) begin
               if (an_ff != NUL) addr = an_ff[SLOT_W-1:0];
               ptr_in = SLOT_W'(1);
            end else begin
               if (an_ff != NUL) begin
                  we = 1'b1; addr = an_ff[SLOT_W-1:0];
                  wdata = pack(blk_l, rd_next, rd_stamp);
               end
               state_in = S_M_WRB;
            end
         end
         S_M_WRB: begin
            we = 1'b1; addr = blk_ff;
            if (op_ff == OP_FIRST) wdata = pack(NUL, t_ff, frm_ff);
            else wdata = pack(aft_l, an_ff, frm_ff);
            state_in = S_DONE;
         end
         // tail freeing
         S_F_RD: begin
            if (tail_ff == NUL || frd_ff == cnt_ff) state_in = S_F_END;
            else begin
               addr = tail_ff[SLOT_W-1:0]; state_in = S_F_CHK;
            end
         end
         S_F_CHK: begin
            if (op_ff == OP_FREE && !(rd_stamp < frm_ff)) state_in = S_F_END;
            else begin
               we = 1'b1; addr = tail_ff[SLOT_W-1:0];
               use_in[tail_ff[SLOT_W-1:0]] = 1'b0;
               tail_in = rd_prev; frd_in = frd_ff + 1'b1;
               state_in = S_F_RD;
            end
         end
         S_F_END: begin
            if (ptr_ff == '0) begin
               if (tail_ff != NUL) begin
                  addr = tail_ff[SLOT_W-1:0]; ptr_in = SLOT_W'(1);
               end else begin
                  head_in = NUL; ptr_in = SLOT_W'(2);
               end
            end else begin
               if (ptr_ff == SLOT_W'(1)) begin
                  we = 1'b1; addr = tail_ff[SLOT_W-1:0];
                  wdata = pack(rd_prev, NUL, rd_stamp);
               end
               used_in = (frd_ff <= used_ff) ? used_ff - frd_ff : '0;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (st_ff == ST_LONE && op_ff == OP_GET) st_in = ST_OK;
            v_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result registers: status fix for get's internal retry marker
   assign rsp_valid           = v_ff;
   assign rsp_status          = st_ff;
   assign rsp_result_block    = (st_ff == ST_OK) ? res_ff : '0;
   assign rsp_freed_count     = frd_ff;
   assign rsp_allocated_count = used_ff;
endmodule
`default_nettype wire

@@ rtl/lbp_checker.sv @@
// ---------------------------------------------------------------------------
// lbp_checker: port-level checks for the LRU block pool
// Watches request/result ports and the allocated count.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module lbp_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_valid,
   input wire logic [2:0] rsp_status,
   input wire logic [5:0] rsp_result_block,
   input wire logic [6:0] rsp_allocated_count
);
   import lbp_pkg::*;

   logic exh_rsp;
   assign exh_rsp = rsp_valid && (rsp_status == ST_EXH);

   `CHK_NEXT(a_busy_after_start, clock, reset, start && !busy, busy, "start not taken")
   `CHK_IMPLY(a_no_rsp_idle, clock, reset, rsp_valid, !busy, "result while busy")
   `CHK_IMPLY(a_alloc_range, clock, reset, rsp_valid, rsp_allocated_count <= 7'd64, "count")
   `CHK_IMPLY(a_exh_zero, clock, reset, exh_rsp, rsp_result_block == '0, "exhausted block")
endmodule
bind lru_block_pool_with_frame_stamps_unit lbp_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_status(rsp_status), .rsp_result_block(rsp_result_block),
   .rsp_allocated_count(rsp_allocated_count)
);
`default_nettype wire

@@ tb/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench: LRU block pool with frame stamps
// Drives get / mark / delete / free-unused commands, predicts every response
// with a local copy of the recency list and checks each strobed response.
// ---------------------------------------------------------------------------
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import lbp_pkg::*;

   localparam int NL = POOL_SIZE;   // null link in the predictor

   typedef struct packed {
      logic [2:0]        status;
      logic [SLOT_W-1:0] blk;
      logic [CNT_W-1:0]  freed;
      logic [CNT_W-1:0]  alloc;
   } rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [2:0]            req_operation = '0;
   logic [SLOT_W-1:0]     req_block_index = '0;
   logic [SLOT_W-1:0]     req_after_index = '0;
   logic [CNT_W-1:0]      req_delete_count = '0;
   logic [FRAME_BITS-1:0] req_frame_id = '0;
   logic                  csr_we = 1'b0;
   logic [CNT_W-1:0]      csr_cache_limit = '0;
   logic                  rsp_valid;
   logic [2:0]            rsp_status;
   logic [SLOT_W-1:0]     rsp_result_block;
   logic [CNT_W-1:0]      rsp_freed_count;
   logic [CNT_W-1:0]      rsp_allocated_count;

   lru_block_pool_with_frame_stamps_unit u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_block_index(req_block_index),
      .req_after_index(req_after_index), .req_delete_count(req_delete_count),
      .req_frame_id(req_frame_id), .csr_we(csr_we),
      .csr_cache_limit(csr_cache_limit), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_result_block(rsp_result_block),
      .rsp_freed_count(rsp_freed_count),
      .rsp_allocated_count(rsp_allocated_count)
   );

   always #4 clock = ~clock;

   // ---- predictor state: mirror of the pool ----
   int   lim;
   int   prv [POOL_SIZE];
   int   nxt [POOL_SIZE];
   int   stamp [POOL_SIZE];
   bit   inuse [POOL_SIZE];
   int   head, tail, used;
   rsp_type pending_rsp [$];
   int   errors = 0;
   int   idle_pct = 0;      // sender gap probability, percent
   int   frame_now = 1;     // slowly advancing frame for random traffic

   function automatic void pool_reset();
      for (int s = 0; s < POOL_SIZE; s++) begin
         prv[s] = NL; nxt[s] = NL; stamp[s] = 0; inuse[s] = 0;
      end
      head = NL; tail = NL; used = 0; lim = CACHE_LIMIT_RESET;
   endfunction

   function automatic int grab_fresh();
      for (int s = 0; s < POOL_SIZE; s++) begin
         if (!inuse[s]) begin
            inuse[s] = 1; prv[s] = NL; nxt[s] = NL; stamp[s] = 0;
            used++;
            return s;
         end
      end
      return NL;
   endfunction

   function automatic void unlink(int s);
      if (prv[s] != NL) nxt[prv[s]] = nxt[s];
      if (nxt[s] != NL) prv[nxt[s]] = prv[s];
   endfunction

   // walk the tail freeing slots; aging mode stops at a fresh enough stamp
   function automatic int drop_tail(int cap, bit aging, int fr);
      int i = 0;
      int t;
      while (tail != NL && i != cap) begin
         t = tail;
         if (aging && !(stamp[t] < fr)) break;
         tail = prv[t];
         inuse[t] = 0; prv[t] = NL; nxt[t] = NL; stamp[t] = 0;
         i++;
      end
      if (tail != NL) nxt[tail] = NL;
      else head = NL;
      used = (i <= used) ? used - i : 0;
      return i;
   endfunction

   function automatic rsp_type pool_step(int op, int b, int a, int cnt, int fr);
      rsp_type r;
      int st = ST_OK, res = 0, fc = 0, s;
      bit ba, aa;
      ba = inuse[b]; aa = inuse[a];
      if (op == OP_GET) begin
         s = NL;
         if (used < lim) s = grab_fresh();
         if (s == NL && tail != NL && (stamp[tail] != fr || stamp[tail] == 0)) begin
            s = tail;
            tail = prv[s];
            if (tail != NL) nxt[tail] = NL;
            if (head == s) head = NL;
            prv[s] = NL; nxt[s] = NL; stamp[s] = 0;
         end
         if (s == NL) s = grab_fresh();
         if (s == NL) st = ST_EXH; else res = s;
      end else if (op == OP_FIRST) begin
         if (!ba) st = ST_EMPTY;
         else if (head == NL) begin
            head = b; tail = b; prv[b] = NL; nxt[b] = NL; stamp[b] = fr;
         end else if (b == head) stamp[b] = fr;
         else begin
            if (b == tail) tail = prv[b];
            unlink(b);
            prv[head] = b; nxt[b] = head; prv[b] = NL; head = b; stamp[b] = fr;
         end
      end else if (op == OP_NEXT) begin
         if (!ba || !aa || head == NL) st = ST_EMPTY;
         else if (b == a) st = ST_SAME;
         else if (!(head == a || prv[a] != NL)) st = ST_EMPTY;
         else if (prv[b] == a) stamp[b] = fr;
         else if (b == head && nxt[b] == NL) st = ST_LONE;
         else begin
            if (b == head) head = nxt[b];
            if (b == tail) tail = prv[b];
            unlink(b);
            nxt[b] = nxt[a];
            if (nxt[b] != NL) prv[nxt[b]] = b;
            prv[b] = a; nxt[a] = b;
            if (a == tail) tail = b;
            stamp[b] = fr;
         end
      end else if (op == OP_DEL) fc = drop_tail(cnt, 0, fr);
      else if (op == OP_FREE) fc = drop_tail(used, 1, fr);
      r.status = st[2:0]; r.blk = res[SLOT_W-1:0];
      r.freed = fc[CNT_W-1:0]; r.alloc = used[CNT_W-1:0];
      return r;
   endfunction

   // ---- one transfer on the command channel ----
   // start stays high after the transfer; an idle gap in the next call or drain() drops it
   task automatic send_cmd(int op, int b, int a, int cnt, int fr);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      req_operation <= op[2:0]; req_block_index <= b[SLOT_W-1:0];
      req_after_index <= a[SLOT_W-1:0]; req_delete_count <= cnt[CNT_W-1:0];
      req_frame_id <= fr[FRAME_BITS-1:0];
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_rsp.push_back(pool_step(op, b, a, cnt, fr));
      @(negedge clock);
   endtask

   // wait for every response, then idle past the slowest operation
   task automatic drain();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   task automatic set_limit(int v);
      drain();
      csr_cache_limit <= v[CNT_W-1:0];
      csr_we <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
      lim = v;
   endtask

   // ---- response checker: a strobe is one transfer, no back-pressure ----
   always @(posedge clock) begin
      rsp_type want, got;
      if (!reset && rsp_valid) begin
         got = {rsp_status, rsp_result_block, rsp_freed_count, rsp_allocated_count};
         if (pending_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response %h", got);
         end else begin
            want = pending_rsp.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10)
                  $display({"mismatch: exp st=%0d blk=%0d freed=%0d alloc=%0d,",
                            " got st=%0d blk=%0d freed=%0d alloc=%0d"},
                           want.status, want.blk, want.freed, want.alloc,
                           got.status, got.blk, got.freed, got.alloc);
            end
         end
      end
   end

   // pick an allocated slot most of the time so marks reach the list logic
   function automatic int pick_slot();
      int s;
      for (int k = 0; k < 8; k++) begin
         s = $urandom_range(POOL_SIZE - 1);
         if (inuse[s]) return s;
      end
      return $urandom_range(POOL_SIZE - 1);
   endfunction

   task automatic test_directed();
      send_cmd(OP_FIRST, 0, 0, 0, 5);           // slot not allocated
      send_cmd(OP_DEL, 0, 0, 64, 0);            // empty list
      send_cmd(OP_FREE, 0, 0, 0, 65535);        // empty list
      send_cmd(OP_NEXT, 1, 0, 0, 3);            // empty list
      for (int i = 0; i < 3; i++) send_cmd(OP_GET, 0, 0, 0, 0);
      send_cmd(OP_NEXT, 0, 0, 0, 1);            // block equals after, but empty list is reported first
      send_cmd(OP_NEXT, 0, 1, 0, 1);            // after not listed
      send_cmd(OP_FIRST, 0, 0, 0, 65535);
      send_cmd(OP_NEXT, 0, 1, 0, 2);            // after unlisted, so empty before the lone-block check
      send_cmd(OP_FIRST, 1, 0, 0, 2);
      send_cmd(OP_NEXT, 1, 0, 0, 2);            // move head behind tail... lone? no
      send_cmd(OP_NEXT, 1, 0, 0, 9);            // already in place: restamp
      send_cmd(OP_FIRST, 2, 0, 0, 7);
      send_cmd(OP_NEXT, 2, 2, 0, 7);
      send_cmd(OP_FREE, 0, 0, 0, 8);
      send_cmd(5, 63, 63, 127, 0);              // unknown operations
      send_cmd(7, 0, 0, 0, 0);
      send_cmd(OP_DEL, 0, 0, 0, 0);             // zero count
      send_cmd(OP_DEL, 63, 63, 127, 65535);
   endtask

   task automatic test_exhaust();
      set_limit(64);
      for (int i = 0; i < 66; i++) send_cmd(OP_GET, 0, 0, 0, 1);  // past the pool
      send_cmd(OP_FIRST, 63, 0, 0, 4);
      send_cmd(OP_NEXT, 5, 63, 0, 4);
      send_cmd(OP_GET, 0, 0, 0, 4);             // tail stamped with frame: exhausted
      send_cmd(OP_GET, 0, 0, 0, 6);             // recycles tail
      send_cmd(OP_DEL, 0, 0, 64, 0);
      drain();
      for (int s = 0; s < POOL_SIZE; s++)
         if (inuse[s]) begin
            send_cmd(OP_FIRST, s, 0, 0, 1);
         end
      send_cmd(OP_DEL, 0, 0, 64, 0);
      set_limit(1);
   endtask

   task automatic test_random(int n);
      int op, b, a, r, c;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 3) frame_now = $urandom_range(65535);
         else if ($urandom_range(9) == 0) frame_now++;
         r = $urandom_range(99);
         b = pick_slot();
         a = pick_slot();
         c = $urandom_range(3) == 0 ? $urandom_range(127) : $urandom_range(4);
         if (r < 30) op = OP_GET;
         else if (r < 55) op = OP_FIRST;
         else if (r < 80) op = OP_NEXT;
         else if (r < 88) op = OP_DEL;
         else if (r < 96) op = OP_FREE;
         else op = $urandom_range(7);
         send_cmd(op, b, a, c, $urandom_range(9) == 0 ? $urandom_range(65535)
                                                    : frame_now & 16'hFFFF);
      end
   endtask

   initial begin
      pool_reset();
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_exhaust();
      idle_pct = 0;  test_random(300);
      set_limit(20);
      idle_pct = 46; test_random(300);
      drain();                                  // sender holds off until idle
      set_limit(0);
      idle_pct = 12; test_random(250);
      set_limit(127);
      idle_pct = 0;  test_random(400);
      drain();
      if (errors == 0 && pending_rsp.size() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      #40ms;
      $display("Some tests failed");
      $finish;
   end
endmodule
`default_nettype wire
